// File: sv/wlcm_pkg.sv
// ----------------------------------------------------------------------------
// wlcm_pkg
// Shared types and constants of the warning light channel mixer.
// ----------------------------------------------------------------------------
package wlcm_pkg;

   // parameter defaults
   localparam int unsigned FULL_LEVEL_DEF    = 100;
   localparam int unsigned NIGHT_DIVISOR_DEF = 2;

   // field widths
   localparam int unsigned CHAN_W  = 5;
   localparam int unsigned MASK_W  = 32;
   localparam int unsigned TIME_W  = 16;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned THR_W   = 8;
   localparam int unsigned MODE_W  = 5;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned DATA_W  = 32;

   // mode flag bit positions
   localparam int unsigned MODE_FLASH    = 0;
   localparam int unsigned MODE_NIGHT    = 1;
   localparam int unsigned MODE_CRUISE   = 2;
   localparam int unsigned MODE_TAKEDOWN = 3;
   localparam int unsigned MODE_OVERHEAT = 4;

   // intensity constants
   localparam logic [VALUE_W-1:0] EMERG_FULL    = 16'hFFFF;
   localparam logic [VALUE_W-1:0] TAKEDOWN_FULL = 16'd65000;
   localparam logic [LEVEL_W-1:0] CRUISE_LEVEL  = 8'd5;
   localparam logic [LEVEL_W-1:0] NIGHT_RESET   = 8'd40;
   localparam logic [THR_W-1:0]   THR_RESET     = 8'd100;
   localparam int unsigned        THR_DIVISOR   = 100;

   typedef enum logic [IDX_W-1:0] {
      CSR_MODE      = 3'd0,
      CSR_TD_SELECT = 3'd1,
      CSR_EMERG_LVL = 3'd2,
      CSR_TD_LVL    = 3'd3,
      CSR_NIGHT_LVL = 3'd4,
      CSR_THROTTLE  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_PWM  = 2'd1,
      KIND_GPIO = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               pin;
      logic [VALUE_W-1:0] full;
      logic [LEVEL_W-1:0] level;
   } mix_sel_type;

endpackage

// File: sv/warning_light_channel_mixer.sv
// ----------------------------------------------------------------------------
// warning_light_channel_mixer
// Per-channel mixer: PWM compare value or GPIO level for one light channel.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_* and pulse start; a request is taken on every clock
//   edge with start high and busy low. busy is always low, so one channel can
//   be taken every cycle.
//   Result: rsp_valid strobes for one cycle with rsp_out_kind,
//   rsp_compare_value and rsp_pin_level. The receiver cannot hold results
//   off, and none is needed: every request yields exactly one result.
//   Pipeline: seven stages (decode, level multiply, two reciprocal divide
//   steps, throttle multiply, two reciprocal divide steps); throughput one
//   request per cycle.
//   Config: csr_valid/csr_ready with csr_index and csr_wdata; csr_ready is
//   always high. Write only while no request is in flight.
//   Reset: synchronous, clears the pipe valids and loads the register
//   defaults; in-flight requests are dropped.
// ----------------------------------------------------------------------------
module warning_light_channel_mixer #(
   parameter int unsigned FULL_LEVEL    = wlcm_pkg::FULL_LEVEL_DEF,
   parameter int unsigned NIGHT_DIVISOR = wlcm_pkg::NIGHT_DIVISOR_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [wlcm_pkg::CHAN_W-1:0]   req_chan_id,
   input  logic                          req_is_takedown,
   input  logic [1:0]                    req_drive_type,
   input  logic                          req_polarity_high,
   input  logic                          req_step_present,
   input  logic [wlcm_pkg::MASK_W-1:0]   req_step_lit_mask,
   input  logic [wlcm_pkg::TIME_W-1:0]   req_step_length,
   input  logic [wlcm_pkg::TIME_W-1:0]   req_step_left,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_out_kind,
   output logic [wlcm_pkg::VALUE_W-1:0]  rsp_compare_value,
   output logic                          rsp_pin_level,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wlcm_pkg::IDX_W-1:0]    csr_index,
   input  logic [wlcm_pkg::DATA_W-1:0]   csr_wdata
);
   import wlcm_pkg::*;

   localparam int unsigned STAGES = 7;
   localparam int unsigned P1_W   = 24;
   localparam int unsigned R1_W   = 25;
   localparam int unsigned X2_W   = 32;
   localparam int unsigned R2_W   = 26;
   localparam int unsigned Q2_W   = 26;
   localparam int unsigned WIN_W  = TIME_W + 6;

   localparam logic [R1_W-1:0]    DIV1_RECIP = R1_W'((64'd1 << P1_W) / FULL_LEVEL);
   localparam logic [R2_W-1:0]    DIV2_RECIP = R2_W'((64'd1 << X2_W) / THR_DIVISOR);
   localparam logic [LEVEL_W-1:0] FULL_L     = LEVEL_W'(FULL_LEVEL);
   localparam logic [WIN_W-1:0]   ND_W       = WIN_W'(NIGHT_DIVISOR);
   localparam logic [TIME_W-1:0]  ND_T       = TIME_W'(NIGHT_DIVISOR);
   localparam logic [6:0]         THR_DIV_L  = 7'(THR_DIVISOR);

   // configuration registers
   logic [MODE_W-1:0]  mode_ff;
   logic [MASK_W-1:0]  td_sel_ff;
   logic [LEVEL_W-1:0] emerg_lvl_ff;
   logic [LEVEL_W-1:0] td_lvl_ff;
   logic [LEVEL_W-1:0] night_lvl_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [LEVEL_W-1:0] wr_level;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_comb begin
      wr_level = {1'b0, csr_wdata[6:0]};
      if (wr_level > FULL_L) begin
         wr_level = FULL_L;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         td_sel_ff    <= '0;
         emerg_lvl_ff <= FULL_L;
         td_lvl_ff    <= FULL_L;
         night_lvl_ff <= NIGHT_RESET;
         thr_ff       <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= csr_wdata[MODE_W-1:0];
            CSR_TD_SELECT: td_sel_ff    <= csr_wdata[MASK_W-1:0];
            CSR_EMERG_LVL: emerg_lvl_ff <= wr_level;
            CSR_TD_LVL:    td_lvl_ff    <= wr_level;
            CSR_NIGHT_LVL: night_lvl_ff <= wr_level;
            CSR_THROTTLE:  thr_ff       <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // stage A: channel decode
   logic [MASK_W-1:0] td_mask;
   logic              td_on;
   logic              run_emerg;
   logic              in_window;
   logic              chan_active;
   logic              lit;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W:0]   elapsed_inc;
   logic [WIN_W-1:0]  win_prod;
   mix_sel_type       sel;

   always_comb begin
      td_mask   = '0;
      if (mode_ff[MODE_TAKEDOWN]) begin
         td_mask = (td_sel_ff == '0) ? '1 : td_sel_ff;
      end
      td_on     = mode_ff[MODE_TAKEDOWN] && !mode_ff[MODE_OVERHEAT];
      run_emerg = mode_ff[MODE_FLASH] && !td_on && !mode_ff[MODE_OVERHEAT];

      elapsed     = (req_step_length > req_step_left) ?
                    req_step_length - req_step_left : '0;
      elapsed_inc = {1'b0, elapsed} + 1'b1;
      win_prod    = {5'd0, elapsed_inc} * ND_W;
      if (req_step_length != '0 && req_step_length < ND_T) begin
         in_window = (elapsed == '0);
      end else begin
         in_window = (win_prod <= {6'd0, req_step_length});
      end

      chan_active = run_emerg && req_step_present &&
                    (!mode_ff[MODE_NIGHT] || in_window) &&
                    req_step_lit_mask[req_chan_id];

      lit       = 1'b0;
      sel.full  = '0;
      sel.level = '0;
      if (mode_ff[MODE_OVERHEAT]) begin
         lit = 1'b0;
      end else if (req_is_takedown) begin
         if (td_on && td_mask[req_chan_id]) begin
            lit       = 1'b1;
            sel.full  = TAKEDOWN_FULL;
            sel.level = td_lvl_ff;
         end
      end else if (run_emerg) begin
         if (chan_active) begin
            lit       = 1'b1;
            sel.full  = EMERG_FULL;
            sel.level = mode_ff[MODE_NIGHT] ? night_lvl_ff : emerg_lvl_ff;
         end else if (mode_ff[MODE_CRUISE]) begin
            lit       = 1'b1;
            sel.full  = EMERG_FULL;
            sel.level = CRUISE_LEVEL;
         end
      end else if (!td_on && mode_ff[MODE_CRUISE]) begin
         lit       = 1'b1;
         sel.full  = EMERG_FULL;
         sel.level = CRUISE_LEVEL;
      end

      case (req_drive_type)
         2'd1:    sel.kind = KIND_PWM;
         2'd2:    sel.kind = KIND_GPIO;
         default: sel.kind = KIND_NONE;
      endcase
      sel.pin = (sel.kind == KIND_GPIO) && (lit == req_polarity_high);
   end

   // pipe valids
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;

   assign vld_in = {vld_ff[STAGES-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // per-stage control carried with the data
   kind_type kind_ff [STAGES];
   logic     pin_ff  [STAGES];

   always_ff @(posedge clock) begin
      kind_ff[0] <= sel.kind;
      pin_ff[0]  <= sel.pin;
      for (int i = 1; i < STAGES; i++) begin
         kind_ff[i] <= kind_ff[i-1];
         pin_ff[i]  <= pin_ff[i-1];
      end
   end

   // datapath
   logic [VALUE_W-1:0]   full_a_ff;
   logic [LEVEL_W-1:0]   level_a_ff;
   logic [P1_W-1:0]      p1_b_ff;
   logic [P1_W-1:0]      p1_c_ff;
   logic [P1_W-1:0]      qe1_c_ff;
   logic [P1_W-1:0]      q1_d_ff;
   logic [X2_W-1:0]      x2_e_ff;
   logic [X2_W-1:0]      x2_f_ff;
   logic [Q2_W-1:0]      qe2_f_ff;
   logic [VALUE_W-1:0]   value_g_ff;

   logic [P1_W+R1_W-1:0] prod1;
   logic [31:0]          back1;
   logic [31:0]          rem1;
   logic [P1_W-1:0]      q1_in;
   logic [X2_W+R2_W-1:0] prod2;
   logic [X2_W+6:0]      back2;
   logic [X2_W-1:0]      rem2;
   logic [Q2_W-1:0]      q2;
   logic [VALUE_W-1:0]   value_in;

   always_comb begin
      prod1 = {{R1_W{1'b0}}, p1_b_ff} * {{P1_W{1'b0}}, DIV1_RECIP};
      back1 = {8'd0, qe1_c_ff} * {24'd0, FULL_L};
      rem1  = {8'd0, p1_c_ff} - back1;
      q1_in = qe1_c_ff + P1_W'(rem1 >= {24'd0, FULL_L});
      prod2 = {{R2_W{1'b0}}, x2_e_ff} * {{X2_W{1'b0}}, DIV2_RECIP};
      back2 = {{(X2_W+7-Q2_W){1'b0}}, qe2_f_ff} * {{(X2_W){1'b0}}, THR_DIV_L};
      rem2  = x2_f_ff - back2[X2_W-1:0];
      q2    = qe2_f_ff + Q2_W'(rem2 >= X2_W'(THR_DIVISOR));
      if (kind_ff[STAGES-2] != KIND_PWM) begin
         value_in = '0;
      end else if (q2 > Q2_W'(16'hFFFF)) begin
         value_in = '1;
      end else begin
         value_in = q2[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      full_a_ff  <= sel.full;
      level_a_ff <= sel.level;
      p1_b_ff    <= {8'd0, full_a_ff} * {16'd0, level_a_ff};
      p1_c_ff    <= p1_b_ff;
      qe1_c_ff   <= prod1[2*P1_W-1:P1_W];
      q1_d_ff    <= q1_in;
      x2_e_ff    <= {8'd0, q1_d_ff} * {24'd0, thr_ff};
      x2_f_ff    <= x2_e_ff;
      qe2_f_ff   <= prod2[X2_W+Q2_W-1:X2_W];
      value_g_ff <= value_in;
   end

   assign rsp_valid         = vld_ff[STAGES-1];
   assign rsp_out_kind      = kind_ff[STAGES-1];
   assign rsp_compare_value = value_g_ff;
   assign rsp_pin_level     = pin_ff[STAGES-1];

   // checks
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, STAGES))
      else $error("result without a request");

   a_gpio_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_PWM |-> rsp_compare_value == '0)
      else $error("compare value on a non-PWM result");

   a_pwm_no_pin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_GPIO |-> !rsp_pin_level)
      else $error("pin level on a non-GPIO result");

   a_overheat_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mode_ff[MODE_OVERHEAT] && $stable(mode_ff) && rsp_out_kind == KIND_PWM
      |-> rsp_compare_value == '0)
      else $error("PWM lit during overheat shutdown");

endmodule
